### rtl/cbs_pkg.sv
// cbs_pkg: shared types, codes and helpers for the cruise-button supervisor
// no dependencies; used by cbs_step and cruise_button_supervisor_fsm_unit
`timescale 1ns / 1ps

package cbs_pkg;

   localparam int CountBits = 16;
   localparam int LimitBits = 16;
   localparam int CmpBits   = (CountBits > LimitBits) ? CountBits : LimitBits;
   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

   // operations
   localparam logic [2:0] OpTick    = 3'd0;
   localparam logic [2:0] OpStatus  = 3'd1;
   localparam logic [2:0] OpObserve = 3'd2;
   localparam logic [2:0] OpRequest = 3'd3;
   localparam logic [2:0] OpSend    = 3'd4;

   // control modes
   localparam logic [2:0] ModeOff     = 3'd0;
   localparam logic [2:0] ModeIdle    = 3'd1;
   localparam logic [2:0] ModeWait    = 3'd2;
   localparam logic [2:0] ModeAllowed = 3'd3;
   localparam logic [2:0] ModeTest    = 3'd4;

   // button check modes
   localparam logic [1:0] CheckPassed  = 2'd0;
   localparam logic [1:0] CheckRunning = 2'd1;
   localparam logic [1:0] CheckFailed  = 2'd2;

   // register indexes
   localparam logic [2:0] CsrTestDelay   = 3'd0;
   localparam logic [2:0] CsrTestLength  = 3'd1;
   localparam logic [2:0] CsrWaitDelay   = 3'd2;
   localparam logic [2:0] CsrHbLimit     = 3'd3;
   localparam logic [2:0] CsrRespLimit   = 3'd4;
   localparam logic [2:0] CsrOffCode     = 3'd5;
   localparam logic [2:0] CsrCancelCode  = 3'd6;

   localparam logic [15:0] TimerReset      = 16'd100;
   localparam logic [7:0]  OffCodeReset    = 8'd0;
   localparam logic [7:0]  CancelCodeReset = 8'd1;

   typedef struct packed {
      logic [2:0] operation;
      logic       cruise_is_on;
      logic       cruise_is_engaged;
      logic [7:0] button_code;
      logic       control_wanted;
   } item_type;

   typedef struct packed {
      logic [15:0] button_test_delay;
      logic [15:0] button_test_length;
      logic [15:0] set_wait_delay;
      logic [15:0] heartbeat_limit;
      logic [15:0] response_limit;
      logic [7:0]  off_button_code;
      logic [7:0]  cancel_button_code;
   } cfg_type;

   typedef struct packed {
      logic [2:0]           ctl_mode;
      logic [1:0]           check_mode;
      logic [CountBits-1:0] off_ticks;
      logic [CountBits-1:0] test_ticks;
      logic [CountBits-1:0] wait_ticks;
      logic [CountBits-1:0] heartbeat_ticks;
      logic [CountBits-1:0] response_ticks;
      logic                 cruise_on_flag;
      logic                 engaged_flag;
      logic                 request_flag;
      logic                 failed_flag;
      logic                 relay_flag;
      logic [7:0]           last_sent_code;
      logic [7:0]           seen_code;
   } state_type;

   typedef struct packed {
      logic       press_valid;
      logic [7:0] press_code;
      logic       relay_on;
      logic [2:0] mode;
      logic       send_accepted;
      logic       link_good;
   } result_type;

   // heartbeat limit clamped to the counter maximum
   function automatic logic [CountBits-1:0] hb_limit(input logic [LimitBits-1:0] lim);
      logic [CmpBits-1:0] wide;
      wide = CmpBits'(lim);
      if (wide < CmpBits'(CountMax)) return CountBits'(wide);
      else return CountMax;
   endfunction

   // compares the count before it advances
   function automatic logic timer_fire(input logic [CountBits-1:0] cnt,
                                       input logic [LimitBits-1:0] lim);
      return CmpBits'(cnt) > CmpBits'(lim);
   endfunction

   function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] cnt);
      if (cnt != CountMax) return cnt + CountBits'(1);
      else return cnt;
   endfunction

endpackage

### rtl/cbs_step.sv
// cbs_step: next state and result word for one accepted word
// depends on cbs_pkg
`timescale 1ns / 1ps

module cbs_step
   import cbs_pkg::*;
(
   input  state_type  cur,
   input  item_type   item,
   input  cfg_type    cfg,
   output state_type  nxt,
   output result_type res
);

   state_type            s;
   logic                 go;
   logic [2:0]           tgt;
   logic                 keep;
   logic                 fire;
   logic                 press_v;
   logic [7:0]           press_c;
   logic                 accepted;
   logic [CountBits-1:0] hb_lim;

   function automatic state_type checked_press(input state_type st, input logic [7:0] code);
      state_type r;
      r = st;
      if (r.check_mode != CheckRunning && r.last_sent_code != code) begin
         r.check_mode     = CheckRunning;
         r.response_ticks = '0;
      end
      r.last_sent_code = code;
      return r;
   endfunction

   assign hb_lim = hb_limit(cfg.heartbeat_limit);

   always_comb begin
      s        = cur;
      go       = 1'b0;
      tgt      = ModeOff;
      keep     = 1'b0;
      fire     = 1'b0;
      press_v  = 1'b0;
      press_c  = 8'd0;
      accepted = 1'b0;
      unique case (item.operation)
         OpTick: begin
            if (!s.cruise_on_flag && s.ctl_mode != ModeOff && s.ctl_mode != ModeTest) begin
               go  = 1'b1;
               tgt = ModeOff;
            end
            if (s.heartbeat_ticks < hb_lim) begin
               s.heartbeat_ticks = sat_inc(s.heartbeat_ticks);
            end
            // mode rules only when the cruise-off rule did not move us
            if (!go) begin
               keep = s.engaged_flag && s.request_flag && (s.heartbeat_ticks < hb_lim);
               unique case (s.ctl_mode)
                  ModeOff: begin
                     if (s.cruise_on_flag) begin
                        go  = 1'b1;
                        tgt = ModeIdle;
                     end else begin
                        fire        = timer_fire(s.off_ticks, cfg.button_test_delay);
                        s.off_ticks = sat_inc(s.off_ticks);
                        go          = fire;
                        tgt         = ModeTest;
                     end
                  end
                  ModeIdle: begin
                     go  = s.engaged_flag && s.request_flag;
                     tgt = ModeWait;
                  end
                  ModeWait: begin
                     if (!keep) begin
                        go  = 1'b1;
                        tgt = ModeIdle;
                     end else begin
                        fire         = timer_fire(s.wait_ticks, cfg.set_wait_delay);
                        s.wait_ticks = sat_inc(s.wait_ticks);
                        go           = fire;
                        tgt          = ModeAllowed;
                     end
                  end
                  ModeAllowed: begin
                     go  = !keep;
                     tgt = ModeIdle;
                  end
                  default: begin
                     if (s.cruise_on_flag) begin
                        go  = 1'b1;
                        tgt = ModeIdle;
                     end else begin
                        fire         = timer_fire(s.test_ticks, cfg.button_test_length);
                        s.test_ticks = sat_inc(s.test_ticks);
                        go           = fire;
                        tgt          = ModeOff;
                     end
                  end
               endcase
            end
            if (go) begin
               unique case (tgt)
                  ModeOff: begin
                     s.relay_flag = 1'b0;
                     press_v      = 1'b1;
                     press_c      = cfg.off_button_code;
                     s.off_ticks  = '0;
                  end
                  ModeIdle: begin
                     s.relay_flag = 1'b0;
                     press_v      = 1'b1;
                     press_c      = cfg.off_button_code;
                  end
                  ModeWait: begin
                     s.wait_ticks = '0;
                  end
                  ModeAllowed: begin
                     s.relay_flag = 1'b1;
                  end
                  default: begin
                     s.relay_flag = 1'b1;
                     press_v      = 1'b1;
                     press_c      = cfg.cancel_button_code;
                     s            = checked_press(s, cfg.cancel_button_code);
                     s.test_ticks = '0;
                  end
               endcase
               s.ctl_mode = tgt;
            end
            // response watchdog runs after any press of this tick
            if (s.check_mode == CheckRunning) begin
               if (timer_fire(s.response_ticks, cfg.response_limit)) begin
                  s.check_mode  = CheckFailed;
                  s.failed_flag = 1'b1;
               end
               s.response_ticks = sat_inc(s.response_ticks);
            end
         end
         OpStatus: begin
            s.cruise_on_flag = item.cruise_is_on;
            s.engaged_flag   = item.cruise_is_engaged;
         end
         OpObserve: begin
            if (s.seen_code != item.button_code) begin
               s.seen_code = item.button_code;
               if (s.check_mode == CheckRunning) begin
                  s.check_mode  = CheckPassed;
                  s.failed_flag = 1'b0;
               end
            end
         end
         OpRequest: begin
            s.request_flag    = item.control_wanted;
            s.heartbeat_ticks = item.control_wanted ? '0 : hb_lim;
         end
         OpSend: begin
            if (s.ctl_mode == ModeAllowed && s.engaged_flag && s.request_flag &&
                s.heartbeat_ticks < hb_lim) begin
               s        = checked_press(s, item.button_code);
               press_v  = 1'b1;
               press_c  = item.button_code;
               accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign nxt               = s;
   assign res.press_valid   = press_v;
   assign res.press_code    = press_c;
   assign res.relay_on      = s.relay_flag;
   assign res.mode          = s.ctl_mode;
   assign res.send_accepted = accepted;
   assign res.link_good     = !s.failed_flag;

endmodule

### rtl/cruise_button_supervisor_fsm_unit.sv
// cruise_button_supervisor_fsm_unit: top level, input/result registers, csr and state
// depends on cbs_pkg and cbs_step
//
//   channel | ports                 | direction | handshake
//   req     | req_operation .. etc. | in        | req_valid / req_stall
//   rsp     | rsp_press_valid .. etc| out       | rsp_valid / rsp_stall
//   csr     | csr_index, csr_data   | in        | csr_write, no wait
//
// one word a cycle sustained while rsp is not stalled; each word passes from req to rsp
// through the input register, then one pass of cbs_step into the result register
// every word yields exactly one result word, rsp_last_of_run always set
// reset is synchronous; it clears control state and loads register defaults
// a stalled rsp holds the result register; req stalls only while the input
// register is full and cannot move on
`timescale 1ns / 1ps

module cruise_button_supervisor_fsm_unit
   import cbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic        req_cruise_is_on,
   input  logic        req_cruise_is_engaged,
   input  logic [7:0]  req_button_code,
   input  logic        req_control_wanted,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_press_valid,
   output logic [7:0]  rsp_press_code,
   output logic        rsp_relay_on,
   output logic [2:0]  rsp_mode,
   output logic        rsp_send_accepted,
   output logic        rsp_link_good,
   output logic        rsp_last_of_run,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in, state_step;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   cbs_step u_step (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg_ff),
      .nxt  (state_step),
      .res  (res_in)
   );

   always_comb begin
      item_in.operation         = req_operation;
      item_in.cruise_is_on      = req_cruise_is_on;
      item_in.cruise_is_engaged = req_cruise_is_engaged;
      item_in.button_code       = req_button_code;
      item_in.control_wanted    = req_control_wanted;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
      state_in = advance ? state_step : state_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CsrTestDelay:  cfg_in.button_test_delay  = csr_data;
            CsrTestLength: cfg_in.button_test_length = csr_data;
            CsrWaitDelay:  cfg_in.set_wait_delay     = csr_data;
            CsrHbLimit:    cfg_in.heartbeat_limit    = csr_data;
            CsrRespLimit:  cfg_in.response_limit     = csr_data;
            CsrOffCode:    cfg_in.off_button_code    = csr_data[7:0];
            CsrCancelCode: cfg_in.cancel_button_code = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.button_test_delay  <= TimerReset;
         cfg_ff.button_test_length <= TimerReset;
         cfg_ff.set_wait_delay     <= TimerReset;
         cfg_ff.heartbeat_limit    <= TimerReset;
         cfg_ff.response_limit     <= TimerReset;
         cfg_ff.off_button_code    <= OffCodeReset;
         cfg_ff.cancel_button_code <= CancelCodeReset;
         state_ff.ctl_mode        <= ModeOff;
         state_ff.check_mode      <= CheckPassed;
         state_ff.off_ticks       <= '0;
         state_ff.test_ticks      <= '0;
         state_ff.wait_ticks      <= '0;
         state_ff.heartbeat_ticks <= hb_limit(TimerReset);
         state_ff.response_ticks  <= '0;
         state_ff.cruise_on_flag  <= 1'b0;
         state_ff.engaged_flag    <= 1'b0;
         state_ff.request_flag    <= 1'b0;
         state_ff.failed_flag     <= 1'b0;
         state_ff.relay_flag      <= 1'b0;
         state_ff.last_sent_code  <= 8'd0;
         state_ff.seen_code       <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_press_valid   = res_ff.press_valid;
   assign rsp_press_code    = res_ff.press_code;
   assign rsp_relay_on      = res_ff.relay_on;
   assign rsp_mode          = res_ff.mode;
   assign rsp_send_accepted = res_ff.send_accepted;
   assign rsp_link_good     = res_ff.link_good;
   assign rsp_last_of_run   = 1'b1;

   // relay is armed exactly in the driving modes, and left alone in set-wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == ModeAllowed || rsp_mode == ModeTest) |-> rsp_relay_on)
      else $error("relay not armed in a driving mode");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == ModeOff || rsp_mode == ModeIdle) |-> !rsp_relay_on)
      else $error("relay armed in off or idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_accepted |-> rsp_press_valid && rsp_mode == ModeAllowed)
      else $error("send accepted without press or outside controls-allowed");

   // a word waiting on a stalled result must not be overwritten
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && rsp_stall |=> in_valid_ff && $stable(item_ff))
      else $error("input register lost a word under stall");

endmodule

### tb/tb_cruise_button_supervisor_fsm_unit.sv
// testbench for cruise_button_supervisor_fsm_unit: directed and random words checked
// against a cycle-free predictor held in a small scoreboard class; needs cbs_pkg and the rtl
`timescale 1ns / 1ps

package tb_sup_pkg;
   import cbs_pkg::*;

   // operation codes the block takes but ignores
   localparam logic [2:0] OpUnusedLo  = 3'd5;
   localparam logic [2:0] OpUnusedMid = 3'd6;
   localparam logic [2:0] OpUnusedHi  = 3'd7;
   localparam int MaxPresses = 2;

   typedef struct packed {
      result_type body;
      logic       last;
   } result_word_type;

   class supervisor_scoreboard;
      logic [15:0] test_delay, test_length, wait_delay, hb_limit_cfg, resp_limit;
      logic [7:0]  off_code, cancel_code;
      logic [2:0]  ctl_mode;
      logic [1:0]  chk_mode;
      logic [CountBits-1:0] off_ticks, test_ticks, wait_ticks, hb_ticks, resp_ticks;
      logic        cruise_on, engaged, requested, link_failed, relay_armed;
      logic [7:0]  last_sent, seen;
      logic [7:0]  presses[$];
      result_word_type due_results[$];
      int          errors;

      function void reset_state();
         test_delay   = TimerReset;
         test_length  = TimerReset;
         wait_delay   = TimerReset;
         hb_limit_cfg = TimerReset;
         resp_limit   = TimerReset;
         off_code     = OffCodeReset;
         cancel_code  = CancelCodeReset;
         ctl_mode     = ModeOff;
         chk_mode     = CheckPassed;
         off_ticks    = '0;
         test_ticks   = '0;
         wait_ticks   = '0;
         resp_ticks   = '0;
         hb_ticks     = hb_clamp();
         cruise_on    = 1'b0;
         engaged      = 1'b0;
         requested    = 1'b0;
         link_failed  = 1'b0;
         relay_armed  = 1'b0;
         last_sent    = '0;
         seen         = '0;
         errors       = 0;
         due_results.delete();
      endfunction

      function void set_register(logic [2:0] idx, logic [15:0] data);
         case (idx)
            CsrTestDelay:  test_delay = data;
            CsrTestLength: test_length = data;
            CsrWaitDelay:  wait_delay = data;
            CsrHbLimit:    hb_limit_cfg = data;
            CsrRespLimit:  resp_limit = data;
            CsrOffCode:    off_code = data[7:0];
            CsrCancelCode: cancel_code = data[7:0];
            default: ;
         endcase
      endfunction

      function logic [CountBits-1:0] hb_clamp();
         if (int'(hb_limit_cfg) < int'(CountMax)) return CountBits'(hb_limit_cfg);
         else return CountMax;
      endfunction

      function logic heartbeat_alive();
         return hb_ticks < hb_clamp();
      endfunction

      // compare the old count, then count up without wrapping
      function logic timer_step(inout logic [CountBits-1:0] cnt, input logic [15:0] lim);
         logic hit;
         hit = longint'(cnt) > longint'(lim);
         if (cnt != CountMax) cnt = cnt + 1'b1;
         return hit;
      endfunction

      function void press(logic [7:0] code);
         if (presses.size() < MaxPresses) presses.push_back(code);
      endfunction

      function void checked_press(logic [7:0] code);
         press(code);
         if (chk_mode != CheckRunning && last_sent != code) begin
            chk_mode   = CheckRunning;
            resp_ticks = '0;
         end
         last_sent = code;
      endfunction

      function void enter_mode(logic [2:0] m);
         case (m)
            ModeOff: begin
               relay_armed = 1'b0;
               press(off_code);
               off_ticks = '0;
            end
            ModeIdle: begin
               relay_armed = 1'b0;
               press(off_code);
            end
            ModeWait: wait_ticks = '0;
            ModeAllowed: relay_armed = 1'b1;
            default: begin
               relay_armed = 1'b1;
               checked_press(cancel_code);
               test_ticks = '0;
            end
         endcase
         ctl_mode = m;
      endfunction

      function void tick();
         logic moved;
         logic keep;
         moved = 1'b0;
         if (!cruise_on && ctl_mode != ModeOff && ctl_mode != ModeTest) begin
            enter_mode(ModeOff);
            moved = 1'b1;
         end
         if (heartbeat_alive() && hb_ticks != CountMax) hb_ticks = hb_ticks + 1'b1;
         // only one mode change per tick; later mode timers do not even count
         if (!moved) begin
            keep = engaged && requested && heartbeat_alive();
            case (ctl_mode)
               ModeOff: begin
                  if (cruise_on) enter_mode(ModeIdle);
                  else if (timer_step(off_ticks, test_delay)) enter_mode(ModeTest);
               end
               ModeIdle: begin
                  if (engaged && requested) enter_mode(ModeWait);
               end
               ModeWait: begin
                  if (!keep) enter_mode(ModeIdle);
                  else if (timer_step(wait_ticks, wait_delay)) enter_mode(ModeAllowed);
               end
               ModeAllowed: begin
                  if (!keep) enter_mode(ModeIdle);
               end
               default: begin
                  if (cruise_on) enter_mode(ModeIdle);
                  else if (timer_step(test_ticks, test_length)) enter_mode(ModeOff);
               end
            endcase
         end
         if (chk_mode == CheckRunning && timer_step(resp_ticks, resp_limit)) begin
            chk_mode    = CheckFailed;
            link_failed = 1'b1;
         end
      endfunction

      function void note_request(item_type it);
         logic accepted;
         int n;
         result_word_type w;
         accepted = 1'b0;
         presses.delete();
         case (it.operation)
            OpTick: tick();
            OpStatus: begin
               cruise_on = it.cruise_is_on;
               engaged   = it.cruise_is_engaged;
            end
            OpObserve: begin
               if (seen != it.button_code) begin
                  seen = it.button_code;
                  if (chk_mode == CheckRunning) begin
                     chk_mode    = CheckPassed;
                     link_failed = 1'b0;
                  end
               end
            end
            OpRequest: begin
               requested = it.control_wanted;
               hb_ticks  = requested ? '0 : hb_clamp();
            end
            OpSend: begin
               if (ctl_mode == ModeAllowed && engaged && requested && heartbeat_alive()) begin
                  checked_press(it.button_code);
                  accepted = 1'b1;
               end
            end
            default: ;
         endcase
         n = (presses.size() > 0) ? presses.size() : 1;
         for (int k = 0; k < n; k++) begin
            w.body.press_valid   = k < presses.size();
            w.body.press_code    = (k < presses.size()) ? presses[k] : 8'h00;
            w.body.relay_on      = relay_armed;
            w.body.mode          = ctl_mode;
            w.body.send_accepted = accepted;
            w.body.link_good     = !link_failed;
            w.last               = k == n - 1;
            due_results.push_back(w);
         end
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(result_type got, logic got_last);
         result_word_type want;
         if (due_results.size() == 0) begin
            $display("%0t result word with nothing pending: expected none, actual %0h",
                     $time, got);
            errors++;
            return;
         end
         want = due_results.pop_front();
         compare("press_valid", want.body.press_valid, got.press_valid);
         compare("press_code", want.body.press_code, got.press_code);
         compare("relay_on", want.body.relay_on, got.relay_on);
         compare("mode", want.body.mode, got.mode);
         compare("send_accepted", want.body.send_accepted, got.send_accepted);
         compare("link_good", want.body.link_good, got.link_good);
         compare("last_of_run", want.last, got_last);
      endfunction
   endclass
endpackage

module tb_cruise_button_supervisor_fsm_unit;
   import cbs_pkg::*;
   import tb_sup_pkg::*;

   localparam int IdleLimit    = 2000;
   localparam int SettleCycles = 4;
   localparam int SatTicks     = 160;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = '0;
   logic        req_cruise_is_on = 1'b0;
   logic        req_cruise_is_engaged = 1'b0;
   logic [7:0]  req_button_code = '0;
   logic        req_control_wanted = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_press_valid;
   logic [7:0]  rsp_press_code;
   logic        rsp_relay_on;
   logic [2:0]  rsp_mode;
   logic        rsp_send_accepted;
   logic        rsp_link_good;
   logic        rsp_last_of_run;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   supervisor_scoreboard board;
   bit valid_up = 1'b0;
   int burst_left = 1;
   int on_bias = 90;
   int engage_bias = 85;
   int quiet_cycles = 0;
   int stall_left = 0;
   int stall_kind = 0;

   cruise_button_supervisor_fsm_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_cruise_is_on      (req_cruise_is_on),
      .req_cruise_is_engaged (req_cruise_is_engaged),
      .req_button_code       (req_button_code),
      .req_control_wanted    (req_control_wanted),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_press_valid       (rsp_press_valid),
      .rsp_press_code        (rsp_press_code),
      .rsp_relay_on          (rsp_relay_on),
      .rsp_mode              (rsp_mode),
      .rsp_send_accepted     (rsp_send_accepted),
      .rsp_link_good         (rsp_link_good),
      .rsp_last_of_run       (rsp_last_of_run),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check each accepted word, then pick the next stall value
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.press_valid   = rsp_press_valid;
         got.press_code    = rsp_press_code;
         got.relay_on      = rsp_relay_on;
         got.mode          = rsp_mode;
         got.send_accepted = rsp_send_accepted;
         got.link_good     = rsp_link_good;
         board.check_response(got, rsp_last_of_run);
      end
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (stall_kind)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= !rsp_stall;
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= $urandom_range(0, 4) != 0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function item_type make_item(logic [2:0] op, logic on, logic eng, logic [7:0] code,
                                logic want);
      item_type it;
      it.operation         = op;
      it.cruise_is_on      = on;
      it.cruise_is_engaged = eng;
      it.button_code       = code;
      it.control_wanted    = want;
      return it;
   endfunction

   // mostly plausible traffic: cruise on and engaged, requests refreshed
   function item_type random_item();
      item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) it.operation = OpTick;
      else if (pick < 52) it.operation = OpStatus;
      else if (pick < 62) it.operation = OpObserve;
      else if (pick < 80) it.operation = OpRequest;
      else if (pick < 96) it.operation = OpSend;
      else it.operation = 3'($urandom_range(int'(OpUnusedLo), int'(OpUnusedHi)));
      it.cruise_is_on      = $urandom_range(0, 99) < on_bias;
      it.cruise_is_engaged = $urandom_range(0, 99) < engage_bias;
      it.button_code       = 8'($urandom_range(0, 255));
      it.control_wanted    = $urandom_range(0, 99) < 85;
      return it;
   endfunction

   task automatic lower_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   task automatic send_request(item_type it);
      req_valid             <= 1'b1;
      valid_up = 1'b1;
      req_operation         <= it.operation;
      req_cruise_is_on      <= it.cruise_is_on;
      req_cruise_is_engaged <= it.cruise_is_engaged;
      req_button_code       <= it.button_code;
      req_control_wanted    <= it.control_wanted;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(it);
   endtask

   // sender works in bursts with gaps in between
   task automatic feed(item_type it);
      send_request(it);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            lower_valid();
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      lower_valid();
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      board.set_register(idx, data);
   endtask

   task automatic load_settings(logic [15:0] test_delay, logic [15:0] test_length,
                                logic [15:0] wait_delay, logic [15:0] hb_limit_v,
                                logic [15:0] resp_limit, logic [15:0] off_code,
                                logic [15:0] cancel_code);
      write_reg(CsrTestDelay, test_delay);
      write_reg(CsrTestLength, test_length);
      write_reg(CsrWaitDelay, wait_delay);
      write_reg(CsrHbLimit, hb_limit_v);
      write_reg(CsrRespLimit, resp_limit);
      write_reg(CsrOffCode, off_code);
      write_reg(CsrCancelCode, cancel_code);
      csr_write <= 1'b0;
   endtask

   task automatic load_small_settings();
      load_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                    16'($urandom_range(0, 6)), 16'($urandom_range(2, 40)),
                    16'($urandom_range(0, 12)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
   endtask

   task automatic run_random(int count, int on_pct, int engage_pct);
      on_bias     = on_pct;
      engage_bias = engage_pct;
      repeat (count) feed(random_item());
      settle();
   endtask

   initial begin
      board = new();
      board.reset_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // walk the mode machine by hand with short timers
      load_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'h00FF, 16'h0000);
      feed(make_item(OpUnusedLo, 1'b1, 1'b1, 8'hFF, 1'b1));
      feed(make_item(OpUnusedMid, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpUnusedHi, 1'b1, 1'b0, 8'h81, 1'b1));
      feed(make_item(OpSend, 1'b0, 1'b0, 8'hFF, 1'b0));          // refused while off
      feed(make_item(OpStatus, 1'b1, 1'b1, 8'h00, 1'b0));
      feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpRequest, 1'b0, 1'b0, 8'h00, 1'b1));
      repeat (3) feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpSend, 1'b0, 1'b0, 8'hA5, 1'b0));
      feed(make_item(OpSend, 1'b0, 1'b0, 8'h00, 1'b0));          // check already running
      feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpObserve, 1'b0, 1'b0, 8'hA5, 1'b0));
      feed(make_item(OpSend, 1'b0, 1'b0, 8'h5A, 1'b0));
      repeat (2) feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0)); // link times out
      feed(make_item(OpRequest, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpSend, 1'b1, 1'b1, 8'h3C, 1'b1));          // no heartbeat
      feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpStatus, 1'b0, 1'b0, 8'h00, 1'b0));
      repeat (5) feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0)); // forced off, test, off
      settle();

      load_small_settings();
      run_random(170, 90, 85);

      load_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'h0000, 16'h00FF);
      run_random(170, 90, 85);

      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF00, 16'h00FF);
      run_random(120, 50, 50);

      // long stay in off with a check running and limits at the top of their range
      load_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      feed(make_item(OpStatus, 1'b1, 1'b1, 8'h00, 1'b0));
      feed(make_item(OpRequest, 1'b0, 1'b0, 8'h00, 1'b1));
      repeat (5) feed(make_item(OpTick, 1'b0, 1'b0, 8'h00, 1'b0));
      feed(make_item(OpSend, 1'b0, 1'b0, 8'h11, 1'b0));
      feed(make_item(OpSend, 1'b0, 1'b0, 8'h22, 1'b0));
      feed(make_item(OpStatus, 1'b0, 1'b0, 8'h00, 1'b0));
      repeat (SatTicks) feed(make_item(OpTick, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1))));
      settle();

      load_small_settings();
      run_random(170, 90, 85);

      load_small_settings();
      run_random(170, 75, 70);

      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
rtl/cbs_pkg.sv
rtl/cbs_step.sv
rtl/cruise_button_supervisor_fsm_unit.sv
tb/tb_cruise_button_supervisor_fsm_unit.sv
